[sv/aod_pkg.sv]
// Shared constants for the approximate octagonal diameter block.
// Fixed-point scale, default sizes and result field widths; no dependencies.
package aod_pkg;

   // Q0.16 fixed point: c = sqrt(2) - 1 and the weight of one unit
   localparam int FRAC_BITS = 16;
   localparam int C_Q16     = 27146;

   // Default sizes handed to the top level
   localparam int MAX_POINTS_DEF = 65536;
   localparam int COORD_BITS_DEF = 16;

   // Projection groups and the extremes they keep (a max and a min each)
   localparam int NUM_GROUPS  = 4;
   localparam int NUM_EXTREME = 2 * NUM_GROUPS;

   // Result field widths
   localparam int IDX_OUT_W  = 17;
   localparam int DIST_OUT_W = 33;

   // Projection group codes
   typedef enum logic [1:0] {
      GRP_X_MINUS_CY = 2'd0,
      GRP_X_PLUS_CY  = 2'd1,
      GRP_Y_MINUS_CX = 2'd2,
      GRP_Y_PLUS_CX  = 2'd3
   } group_type;

endpackage

[sv/aod_if.sv]
// Point and result channel interfaces for the octagonal diameter block.
// Depends on aod_pkg for default widths and result field widths.
interface aod_req_if #(
   parameter int COORD_BITS = aod_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] x_coord;
   logic signed [COORD_BITS-1:0] y_coord;
   logic                         last_point;

   modport source (output valid, output x_coord, output y_coord, output last_point,
                   input ready);
   modport sink   (input valid, input x_coord, input y_coord, input last_point,
                   output ready);
endinterface

interface aod_rsp_if;
   import aod_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [IDX_OUT_W-1:0]  first_index;
   logic [IDX_OUT_W-1:0]  second_index;
   logic [DIST_OUT_W-1:0] best_distance;
   logic                  overflowed;

   modport source (output valid, output first_index, output second_index,
                   output best_distance, output overflowed, input ready);
   modport sink   (input valid, input first_index, input second_index,
                   input best_distance, input overflowed, output ready);
endinterface

[sv/aod_pair_score.sv]
// Octagonal distance and ordered index pair of one max/min extreme pair.
// Depends on aod_pkg for the Q0.16 constant.
module aod_pair_score #(
   parameter int COORD_BITS = aod_pkg::COORD_BITS_DEF,
   parameter int IDX_W      = 16,
   parameter int DIST_W     = COORD_BITS + aod_pkg::FRAC_BITS + 1
) (
   input  logic [IDX_W-1:0]             a_idx,
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic [IDX_W-1:0]             b_idx,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   output logic [DIST_W-1:0]            score,
   output logic [IDX_W-1:0]             lo_idx,
   output logic [IDX_W-1:0]             hi_idx
);
   import aod_pkg::*;

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic [COORD_BITS:0]        dx_abs;
   logic [COORD_BITS:0]        dy_abs;
   logic [COORD_BITS-1:0]      big;
   logic [COORD_BITS-1:0]      little;

   always_comb begin
      dx     = (COORD_BITS+1)'(a_x) - (COORD_BITS+1)'(b_x);
      dy     = (COORD_BITS+1)'(a_y) - (COORD_BITS+1)'(b_y);
      dx_abs = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
      dy_abs = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
      // a difference of two coordinates never exceeds 2^COORD_BITS - 1
      if (dx_abs > dy_abs) begin
         big    = dx_abs[COORD_BITS-1:0];
         little = dy_abs[COORD_BITS-1:0];
      end else begin
         big    = dy_abs[COORD_BITS-1:0];
         little = dx_abs[COORD_BITS-1:0];
      end
      score = (DIST_W'(big) << FRAC_BITS) + DIST_W'(little) * DIST_W'(C_Q16);
      if (a_idx < b_idx) begin
         lo_idx = a_idx;
         hi_idx = b_idx;
      end else begin
         lo_idx = b_idx;
         hi_idx = a_idx;
      end
   end

endmodule

[sv/approx_octagonal_diameter.sv]
// Top level of the approximate octagonal diameter block.
// Depends on aod_pkg, aod_req_if, aod_rsp_if and aod_pair_score.
//
//   channel | dir | fields                                          | note
//   req     | in  | x_coord, y_coord, last_point                    | one point per beat
//   rsp     | out | first_index, second_index, best_distance,       | one beat per point set,
//           |     | overflowed                                      | on the last point
//
// Takes one point every cycle while req is ready. A point folds into the eight
// extremes on the edge that it leaves the input register; a last point is
// captured in the snapshot on that same edge, then the pair scores are
// registered in the score stage and the best pair in the result register,
// which drives rsp valid. Reset is synchronous and clears only control
// state: valid bits, point count, overflow flag. A stalled rsp beat holds
// the last point in its stage; plain points keep flowing in while a result
// waits, and req stalls only once a last point cannot move on.
module approx_octagonal_diameter #(
   parameter int MAX_POINTS = aod_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = aod_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   aod_req_if.sink    req,
   aod_rsp_if.source  rsp
);
   import aod_pkg::*;

   localparam int IDX_W  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int PROJ_W = COORD_BITS + FRAC_BITS + 1;
   localparam int DIST_W = COORD_BITS + FRAC_BITS + 1;
   localparam int WIDE_W = 64;

   // ---------------------------------------------------------------- input stage
   logic                         s1_v_ff, s1_v_in;
   logic signed [COORD_BITS-1:0] s1_x_ff, s1_y_ff;
   logic                         s1_last_ff;

   // ---------------------------------------------------------------- live set state
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         ovf_ff, ovf_in;
   logic [IDX_W-1:0]             ext_idx_ff  [NUM_EXTREME];
   logic signed [COORD_BITS-1:0] ext_x_ff    [NUM_EXTREME];
   logic signed [COORD_BITS-1:0] ext_y_ff    [NUM_EXTREME];
   logic signed [PROJ_W-1:0]     ext_proj_ff [NUM_EXTREME];
   logic [IDX_W-1:0]             ext_idx_in  [NUM_EXTREME];
   logic signed [COORD_BITS-1:0] ext_x_in    [NUM_EXTREME];
   logic signed [COORD_BITS-1:0] ext_y_in    [NUM_EXTREME];
   logic signed [PROJ_W-1:0]     ext_proj_in [NUM_EXTREME];
   logic signed [PROJ_W-1:0]     proj        [NUM_GROUPS];
   logic                         upd_ovf;

   // ---------------------------------------------------------------- snapshot stage
   logic                         s2_v_ff, s2_v_in;
   logic [IDX_W-1:0]             snap_idx_ff [NUM_EXTREME];
   logic signed [COORD_BITS-1:0] snap_x_ff   [NUM_EXTREME];
   logic signed [COORD_BITS-1:0] snap_y_ff   [NUM_EXTREME];
   logic                         snap_ovf_ff;

   // ---------------------------------------------------------------- score stage
   logic                         s3_v_ff, s3_v_in;
   logic [DIST_W-1:0]            s3_dist_ff [NUM_GROUPS];
   logic [IDX_W-1:0]             s3_lo_ff   [NUM_GROUPS];
   logic [IDX_W-1:0]             s3_hi_ff   [NUM_GROUPS];
   logic                         s3_ovf_ff;
   logic [DIST_W-1:0]            pair_dist  [NUM_GROUPS];
   logic [IDX_W-1:0]             pair_lo    [NUM_GROUPS];
   logic [IDX_W-1:0]             pair_hi    [NUM_GROUPS];

   // ---------------------------------------------------------------- result stage
   logic                         rsp_v_ff, rsp_v_in;
   logic [IDX_OUT_W-1:0]         rsp_first_ff, rsp_first_in;
   logic [IDX_OUT_W-1:0]         rsp_second_ff, rsp_second_in;
   logic [DIST_OUT_W-1:0]        rsp_dist_ff, rsp_dist_in;
   logic                         rsp_ovf_ff;
   logic [DIST_W-1:0]            best_dist;
   logic [IDX_W-1:0]             best_lo, best_hi;
   logic [WIDE_W-1:0]            wide_first, wide_second, wide_dist;

   // ---------------------------------------------------------------- flow control
   logic out_free, s3_free, s2_free, s1_leave;
   logic s1_load, s2_load, s3_load, out_load;

   always_comb begin
      out_free = !rsp_v_ff || rsp.ready;
      s3_free  = !s3_v_ff || out_free;
      s2_free  = !s2_v_ff || s3_free;
      // a plain point always folds into the state; a last point needs the snapshot
      s1_leave = s1_v_ff && (!s1_last_ff || s2_free);
      s1_load  = req.valid && req.ready;
      s2_load  = s1_leave && s1_last_ff;
      s3_load  = s2_v_ff && s3_free;
      out_load = s3_v_ff && out_free;
      s1_v_in  = s1_load || (s1_v_ff && !s1_leave);
      s2_v_in  = s2_load || (s2_v_ff && !s3_free);
      s3_v_in  = s3_load || (s3_v_ff && !out_free);
      rsp_v_in = out_load || (rsp_v_ff && !rsp.ready);
   end

   assign req.ready = !s1_v_ff || s1_leave;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // Hold the accepted point until it folds into the state
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_x_ff    <= req.x_coord;
         s1_y_ff    <= req.y_coord;
         s1_last_ff <= req.last_point;
      end
   end

   // ---------------------------------------------------------------- extreme update
   // Project the point onto the four directions: a*1 +/- b*c in Q.16
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         case (group_type'(g))
            GRP_X_MINUS_CY: proj[g] = (PROJ_W'(s1_x_ff) <<< FRAC_BITS)
                                      - PROJ_W'(s1_y_ff) * PROJ_W'(C_Q16);
            GRP_X_PLUS_CY:  proj[g] = (PROJ_W'(s1_x_ff) <<< FRAC_BITS)
                                      + PROJ_W'(s1_y_ff) * PROJ_W'(C_Q16);
            GRP_Y_MINUS_CX: proj[g] = (PROJ_W'(s1_y_ff) <<< FRAC_BITS)
                                      - PROJ_W'(s1_x_ff) * PROJ_W'(C_Q16);
            default:        proj[g] = (PROJ_W'(s1_y_ff) <<< FRAC_BITS)
                                      + PROJ_W'(s1_x_ff) * PROJ_W'(C_Q16);
         endcase
      end
   end

   // Even slots keep the max of their group, odd slots the min; ties keep the old one
   always_comb begin
      ext_idx_in  = ext_idx_ff;
      ext_x_in    = ext_x_ff;
      ext_y_in    = ext_y_ff;
      ext_proj_in = ext_proj_ff;
      upd_ovf     = ovf_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      if (s1_leave) begin
         if (cnt_ff == CNT_W'(MAX_POINTS)) begin
            upd_ovf = 1'b1;
         end else begin
            for (int e = 0; e < NUM_EXTREME; e++) begin
               if ((cnt_ff == '0) ||
                   ((e % 2 == 0) && (proj[e >> 1] > ext_proj_ff[e])) ||
                   ((e % 2 == 1) && (proj[e >> 1] < ext_proj_ff[e]))) begin
                  ext_idx_in[e]  = cnt_ff[IDX_W-1:0];
                  ext_x_in[e]    = s1_x_ff;
                  ext_y_in[e]    = s1_y_ff;
                  ext_proj_in[e] = proj[e >> 1];
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ovf_in = upd_ovf;
         // a last point closes the set: start the next one empty
         if (s1_last_ff) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      ext_idx_ff  <= ext_idx_in;
      ext_x_ff    <= ext_x_in;
      ext_y_ff    <= ext_y_in;
      ext_proj_ff <= ext_proj_in;
   end

   // Capture the finished extremes of a set
   always_ff @(posedge clock) begin
      if (s2_load) begin
         snap_idx_ff <= ext_idx_in;
         snap_x_ff   <= ext_x_in;
         snap_y_ff   <= ext_y_in;
         snap_ovf_ff <= upd_ovf;
      end
   end

   // ---------------------------------------------------------------- pair scoring
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_pair
      aod_pair_score #(
         .COORD_BITS (COORD_BITS),
         .IDX_W      (IDX_W),
         .DIST_W     (DIST_W)
      ) u_pair_score (
         .a_idx  (snap_idx_ff[2*g]),
         .a_x    (snap_x_ff[2*g]),
         .a_y    (snap_y_ff[2*g]),
         .b_idx  (snap_idx_ff[2*g+1]),
         .b_x    (snap_x_ff[2*g+1]),
         .b_y    (snap_y_ff[2*g+1]),
         .score  (pair_dist[g]),
         .lo_idx (pair_lo[g]),
         .hi_idx (pair_hi[g])
      );
   end

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_dist_ff <= pair_dist;
         s3_lo_ff   <= pair_lo;
         s3_hi_ff   <= pair_hi;
         s3_ovf_ff  <= snap_ovf_ff;
      end
   end

   // ---------------------------------------------------------------- best select
   // Scan groups in order; only a strictly larger score wins, floor is (1,1) at zero
   always_comb begin
      best_dist = '0;
      best_lo   = '0;
      best_hi   = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (s3_dist_ff[g] > best_dist) begin
            best_dist = s3_dist_ff[g];
            best_lo   = s3_lo_ff[g];
            best_hi   = s3_hi_ff[g];
         end
      end
      // indexes go out 1-based, every field cut to its port width
      wide_first    = WIDE_W'(best_lo) + WIDE_W'(1);
      wide_second   = WIDE_W'(best_hi) + WIDE_W'(1);
      wide_dist     = WIDE_W'(best_dist);
      rsp_first_in  = wide_first[IDX_OUT_W-1:0];
      rsp_second_in = wide_second[IDX_OUT_W-1:0];
      rsp_dist_in   = wide_dist[DIST_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_first_ff  <= rsp_first_in;
         rsp_second_ff <= rsp_second_in;
         rsp_dist_ff   <= rsp_dist_in;
         rsp_ovf_ff    <= s3_ovf_ff;
      end
   end

   assign rsp.valid         = rsp_v_ff;
   assign rsp.first_index   = rsp_first_ff;
   assign rsp.second_index  = rsp_second_ff;
   assign rsp.best_distance = rsp_dist_ff;
   assign rsp.overflowed    = rsp_ovf_ff;

endmodule

[sv/aod_checker.sv]
// Port-level checks for approx_octagonal_diameter, bound to every instance.
// Depends on aod_pkg for the result field widths.
module aod_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_last_point,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [aod_pkg::IDX_OUT_W-1:0]  rsp_first_index,
   input logic [aod_pkg::IDX_OUT_W-1:0]  rsp_second_index,
   input logic [aod_pkg::DIST_OUT_W-1:0] rsp_best_distance,
   input logic                           rsp_overflowed
);
   import aod_pkg::*;

   // last points taken in but not yet delivered as results
   logic [2:0] pending_ff, pending_in;
   logic       last_beat, rsp_beat;

   always_comb begin
      last_beat  = req_valid && req_ready && req_last_point;
      rsp_beat   = rsp_valid && rsp_ready;
      pending_in = pending_ff + 3'(last_beat) - 3'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_index)
         && $stable(rsp_second_index) && $stable(rsp_best_distance)
         && $stable(rsp_overflowed))
      else $error("rsp beat changed while stalled");

   a_rsp_has_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0 && pending_ff <= 3'd4)
      else $error("result without a matching last point");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_first_index != '0 && rsp_first_index <= rsp_second_index)
      else $error("result index pair out of order");

   a_zero_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_best_distance == '0 |->
         rsp_first_index == IDX_OUT_W'(1) && rsp_second_index == IDX_OUT_W'(1))
      else $error("zero distance must report the first point pair");

endmodule

bind approx_octagonal_diameter aod_checker u_aod_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .req_last_point    (req.last_point),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_first_index   (rsp.first_index),
   .rsp_second_index  (rsp.second_index),
   .rsp_best_distance (rsp.best_distance),
   .rsp_overflowed    (rsp.overflowed)
);
